// File: design/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg: shared types and constants of the keyframe linear sampler
// Holds the table size, fixed-point format, word types and status codes.
// ----------------------------------------------------------------------------
package kls_pkg;

    localparam int MAX_KEYS   = 64;
    localparam int FRAC_BITS  = 16;

    localparam int ADDR_W     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W      = $clog2(MAX_KEYS + 1);

    // fraction runs from 0 to 2^FRAC_BITS inclusive
    localparam int QUOT_W     = FRAC_BITS + 1;
    localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);
    localparam int PROD_W     = 33 + QUOT_W + 1;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef logic [2:0][31:0] vec_t;

    typedef struct packed {
        logic               cmd;
        logic               first_key;
        logic [31:0]        time_value;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        status_t            status;
    } out_word_t;

    typedef struct packed {
        logic [31:0] key_time;
        vec_t        val;
    } key_entry_t;

endpackage

// File: design/kls_ram.sv
// ----------------------------------------------------------------------------
// kls_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module kls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/kls_div.sv
// ----------------------------------------------------------------------------
// kls_div: restoring fraction divider
// Gives floor(numer * 2^FRAC_BITS / denom) for numer <= denom, one bit a cycle.
// ----------------------------------------------------------------------------
module kls_div
    import kls_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [31:0]       numer,
    input  logic [31:0]       denom,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [32:0]          rem_reg, rem_next;
    logic [31:0]          den_reg, den_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;

    logic                 bit_set;
    logic [32:0]          rem_sub;

    always_comb begin
        bit_set   = rem_reg >= {1'b0, den_reg};
        rem_sub   = bit_set ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(QUOT_W);
            rem_next  = {1'b0, numer};
            den_next  = denom;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the shift never overflows
            rem_next  = {rem_sub[31:0], 1'b0};
            quot_next = {quot_reg[QUOT_W-2:0], bit_set};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: design/keyframe_linear_sampler.sv
// ----------------------------------------------------------------------------
// keyframe_linear_sampler: keyframe table with linear sampling
// Appends time-stamped three-component keys to a RAM table and returns the
// vector interpolated between the first bracketing pair of keys.
// ----------------------------------------------------------------------------
//
//  channel   ports                      word        direction
//  --------  -------------------------  ----------  ---------
//  input     s_valid s_ready s_data     in_word_t   in
//  result    m_valid m_ready m_data     out_word_t  out
//
//  An append writes the table and passes through S_DONE to its result word;
//  the next word is taken once the block is back in S_IDLE. A sample reads one
//  table entry a cycle over the N keys it visits, then runs the fraction
//  division, the lerp in S_SUB, S_MUL and S_ADD (one shared multiplier, three
//  components in turn) and loads the result in S_DONE.
//  One item is in work at a time; the next word is taken while a finished
//  result still waits in the output register. Reset empties the table; the
//  table RAM itself is not cleared. A stalled result only delays return to idle.
//
module keyframe_linear_sampler
    import kls_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FIRST = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_SUB   = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_ADD   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         key_count_reg, key_count_next;
    logic [31:0]              tv_reg, tv_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    key_entry_t               prev_reg, prev_next;
    key_entry_t               cur_reg, cur_next;
    logic [1:0]               comp_reg, comp_next;
    logic signed [32:0]       diff_reg, diff_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    vec_t                     res_vec_reg, res_vec_next;
    status_t                  res_status_reg, res_status_next;
    logic                     m_valid_reg, m_valid_next;
    out_word_t                m_data_reg, m_data_next;

    // table RAM
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    key_entry_t               ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    key_entry_t               ram_rdata;

    // fraction divider
    logic                     div_start;
    logic [31:0]              div_numer;
    logic [31:0]              div_denom;
    logic                     div_done;
    logic [QUOT_W-1:0]        div_quot;

    logic                     out_load;
    logic [CNT_W-1:0]         cnt_eff;
    logic                     idx_is_last;
    logic [31:0]              comp_a;
    logic [31:0]              comp_b;

    kls_ram #(
        .WIDTH ($bits(key_entry_t)),
        .DEPTH (MAX_KEYS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kls_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_ready = (state_reg == S_IDLE);
    // hand the result over once the output register is free or being drained
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // first_key restarts the table before the append lands
    assign cnt_eff     = s_data.first_key ? '0 : key_count_reg;
    assign idx_is_last = (CNT_W'(idx_reg) + CNT_W'(1)) == key_count_reg;
    assign comp_a      = prev_reg.val[comp_reg];
    assign comp_b      = cur_reg.val[comp_reg];

    always_comb begin
        state_next      = state_reg;
        key_count_next  = key_count_reg;
        tv_next         = tv_reg;
        idx_next        = idx_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        comp_next       = comp_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        res_vec_next    = res_vec_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_eff[ADDR_W-1:0];
        ram_wdata       = '{key_time: s_data.time_value,
                            val: {s_data.key_z, s_data.key_y, s_data.key_x}};
        ram_raddr       = '0;
        div_start       = 1'b0;
        div_numer       = tv_reg - prev_reg.key_time;
        div_denom       = ram_rdata.key_time - prev_reg.key_time;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    tv_next         = s_data.time_value;
                    res_vec_next    = '0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    if (s_data.cmd == CMD_APPEND) begin
                        if (cnt_eff >= CNT_W'(MAX_KEYS)) begin
                            // drop the key, table stays as it is
                            res_status_next = ST_FULL;
                        end else begin
                            ram_we         = 1'b1;
                            key_count_next = cnt_eff + CNT_W'(1);
                        end
                    end else if (key_count_reg == '0) begin
                        res_status_next = ST_EMPTY;
                    end else begin
                        ram_raddr  = '0;
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                // entry 0 on the read port
                if (key_count_reg == CNT_W'(1) || tv_reg <= ram_rdata.key_time) begin
                    res_vec_next = ram_rdata.val;
                    state_next   = S_DONE;
                end else begin
                    prev_next  = ram_rdata;
                    idx_next   = ADDR_W'(1);
                    ram_raddr  = ADDR_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // prev_reg holds entry idx-1, the read port entry idx
                if (prev_reg.key_time <= tv_reg && tv_reg <= ram_rdata.key_time) begin
                    if (prev_reg.key_time == ram_rdata.key_time) begin
                        res_vec_next = prev_reg.val;
                        state_next   = S_DONE;
                    end else begin
                        cur_next   = ram_rdata;
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end else if (idx_is_last) begin
                    // past the last key: hold the last value
                    res_vec_next = ram_rdata.val;
                    state_next   = S_DONE;
                end else begin
                    prev_next = ram_rdata;
                    idx_next  = idx_reg + ADDR_W'(1);
                    ram_raddr = idx_reg + ADDR_W'(1);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    comp_next  = '0;
                    state_next = S_SUB;
                end
            end
            S_SUB: begin
                diff_next  = $signed({comp_b[31], comp_b}) - $signed({comp_a[31], comp_a});
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = diff_reg * $signed({1'b0, div_quot});
                state_next = S_ADD;
            end
            S_ADD: begin
                // arithmetic shift floors the scaled difference
                res_vec_next[comp_reg] = comp_a + prod_reg[FRAC_BITS +: 32];
                if (comp_reg == 2'd2) begin
                    state_next = S_DONE;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_SUB;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next       = 1'b1;
            m_data_next.out_x  = res_vec_reg[0];
            m_data_next.out_y  = res_vec_reg[1];
            m_data_next.out_z  = res_vec_reg[2];
            m_data_next.status = res_status_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            key_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            m_valid_reg   <= m_valid_next;
        end
        tv_reg         <= tv_next;
        idx_reg        <= idx_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        comp_reg       <= comp_next;
        diff_reg       <= diff_next;
        prod_reg       <= prod_next;
        res_vec_reg    <= res_vec_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // table never holds more keys than it has entries
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        key_count_reg <= CNT_W'(MAX_KEYS))
        else $error("key count beyond table size");

    // a divider result arrives only while the sequencer waits for it
    a_div_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    // the pair scan runs only on a table with at least two keys
    a_scan_two_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> key_count_reg >= CNT_W'(2))
        else $error("scan on a table with fewer than two keys");

    // a finished result goes straight into a free output register
    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && !m_valid_reg) |=> m_valid_reg)
        else $error("finished result not loaded into the output register");

endmodule

// File: tb/keyframe_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_sample_checker: result checker for the keyframe linear sampler
// Watches both channels, keeps its own keyframe table, predicts each result
// word and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module keyframe_sample_checker
    import kls_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        mismatch_count,
    output int        outstanding,
    output int        words_checked,
    output int        lerps_predicted,
    output int        full_predicted,
    output int        empty_predicted
);

    logic [31:0] key_time_tbl [MAX_KEYS];
    logic [31:0] key_x_tbl    [MAX_KEYS];
    logic [31:0] key_y_tbl    [MAX_KEYS];
    logic [31:0] key_z_tbl    [MAX_KEYS];
    int          key_total;

    out_word_t   pending_results [$];

    // a + floor((b - a) * f / 2^FRAC_BITS), all in 64-bit signed
    function automatic logic [31:0] lerp_component(logic [31:0] a, logic [31:0] b,
                                                   longint unsigned frac);
        longint sa;
        longint diff;
        longint prod;
        sa   = longint'(signed'(a));
        diff = longint'(signed'(b)) - sa;
        prod = diff * longint'(frac);
        return 32'(sa + (prod >>> FRAC_BITS));
    endfunction

    task automatic predict_keyframe_result(input in_word_t w, output out_word_t r);
        int              idx;
        int              pick;
        bit              found;
        bit              blend;
        logic [31:0]     t0;
        logic [31:0]     t1;
        longint unsigned frac;
        r        = '0;
        r.status = ST_OK;
        if (w.cmd == CMD_APPEND) begin
            if (w.first_key)
                key_total = 0;
            if (key_total >= MAX_KEYS) begin
                r.status = ST_FULL;
                full_predicted++;
            end else begin
                key_time_tbl[key_total] = w.time_value;
                key_x_tbl[key_total]    = w.key_x;
                key_y_tbl[key_total]    = w.key_y;
                key_z_tbl[key_total]    = w.key_z;
                key_total++;
            end
        end else if (key_total == 0) begin
            r.status = ST_EMPTY;
            empty_predicted++;
        end else begin
            pick  = key_total - 1;
            found = 1'b0;
            blend = 1'b0;
            if (key_total == 1 || w.time_value <= key_time_tbl[0]) begin
                pick  = 0;
                found = 1'b1;
            end
            // first bracketing pair wins; equal times give the earlier key
            for (idx = 0; idx + 1 < key_total; idx++) begin
                t0 = key_time_tbl[idx];
                t1 = key_time_tbl[idx + 1];
                if (!found && t0 <= w.time_value && w.time_value <= t1) begin
                    found = 1'b1;
                    pick  = idx;
                    blend = (t1 != t0);
                end
            end
            if (blend) begin
                t0   = key_time_tbl[pick];
                t1   = key_time_tbl[pick + 1];
                frac = (longint'(w.time_value - t0) << FRAC_BITS) / longint'(t1 - t0);
                r.out_x = lerp_component(key_x_tbl[pick], key_x_tbl[pick + 1], frac);
                r.out_y = lerp_component(key_y_tbl[pick], key_y_tbl[pick + 1], frac);
                r.out_z = lerp_component(key_z_tbl[pick], key_z_tbl[pick + 1], frac);
                lerps_predicted++;
            end else begin
                r.out_x = key_x_tbl[pick];
                r.out_y = key_y_tbl[pick];
                r.out_z = key_z_tbl[pick];
            end
        end
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        out_word_t got;
        if (!aresetn) begin
            mismatch_count  = 0;
            outstanding     = 0;
            words_checked   = 0;
            lerps_predicted = 0;
            full_predicted  = 0;
            empty_predicted = 0;
            key_total       = 0;
            pending_results.delete();
        end else begin
            // retire the result first so a stray word never meets a fresh entry
            if (m_valid && m_ready) begin
                got = m_data;
                if (pending_results.size() == 0) begin
                    $display("%0t: result word with nothing expected: %h", $time, got);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.out_x !== want.out_x) begin
                        $display("%0t: out_x expected %h actual %h",
                                 $time, want.out_x, got.out_x);
                        mismatch_count++;
                    end
                    if (got.out_y !== want.out_y) begin
                        $display("%0t: out_y expected %h actual %h",
                                 $time, want.out_y, got.out_y);
                        mismatch_count++;
                    end
                    if (got.out_z !== want.out_z) begin
                        $display("%0t: out_z expected %h actual %h",
                                 $time, want.out_z, got.out_z);
                        mismatch_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatch_count++;
                    end
                    words_checked++;
                end
            end
            if (s_valid && s_ready) begin
                predict_keyframe_result(s_data, want);
                pending_results = {pending_results, want};
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// File: tb/tb_keyframe_linear_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_linear_sampler: testbench top for the keyframe linear sampler
// Drives directed and random keyframe tables and sample times through the
// block under four idling patterns and long result back-pressure stretches;
// the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_keyframe_linear_sampler
    import kls_pkg::*;
();

    localparam int ITEMS_PER_PHASE = 375;
    localparam int WATCHDOG_LIMIT  = 4000;  // far beyond a 64-key sample plus the hold-off
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 120;   // a little more than the slowest sample

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    int mismatch_count;
    int outstanding;
    int words_checked;
    int lerps_predicted;
    int full_predicted;
    int empty_predicted;

    // idling pattern of the current phase, in percent per cycle
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int holds_done;
    int words_sent;
    int stall_cycles;

    // stimulus-side copy of the key times, used only to aim sample times
    int          shape_keys;
    logic [31:0] shape_times [MAX_KEYS];
    logic [31:0] step_cap;

    keyframe_linear_sampler dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    keyframe_sample_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .words_checked   (words_checked),
        .lerps_predicted (lerps_predicted),
        .full_predicted  (full_predicted),
        .empty_predicted (empty_predicted)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver: stall at the phase rate, or hold off for a long stretch on
    // request so the block fills up and drops s_ready.
    initial begin
        m_ready    = 1'b0;
        holds_done = 0;
        forever @(negedge aclk) begin
            if (hold_requests != holds_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                holds_done++;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("keyframe_linear_sampler test failed");
            $finish;
        end
    end

    // Offer one word from a falling edge and return at the falling edge after
    // it was taken. Valid stays high into the next word when there is no gap.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
        // track key times for aiming later samples
        if (w.cmd == CMD_APPEND) begin
            if (w.first_key)
                shape_keys = 0;
            if (shape_keys < MAX_KEYS) begin
                shape_times[shape_keys] = w.time_value;
                shape_keys++;
            end
        end
    endtask

    task automatic send_append(input logic first, input logic [31:0] t,
                               input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        in_word_t w;
        w.cmd        = CMD_APPEND;
        w.first_key  = first;
        w.time_value = t;
        w.key_x      = x;
        w.key_y      = y;
        w.key_z      = z;
        send_word(w);
    endtask

    // key fields and first_key carry noise on a sample; the block ignores them
    task automatic send_sample(input logic [31:0] t);
        in_word_t w;
        w.cmd        = CMD_SAMPLE;
        w.first_key  = 1'($urandom_range(0, 1));
        w.time_value = t;
        w.key_x      = $urandom;
        w.key_y      = $urandom;
        w.key_z      = $urandom;
        send_word(w);
    endtask

    function automatic logic [31:0] rand_component();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'h8000_0000;
        if (r < 16)
            return 32'h7FFF_FFFF;
        if (r < 26)
            return 32'($urandom_range(0, 511)) - 32'd256;
        return $urandom;
    endfunction

    function automatic logic [31:0] next_key_time(input logic [31:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return prev;                 // equal times
        if (r < 15)
            return $urandom;             // out of order
        if (r < 20)
            return prev + 32'd1;
        return prev + $urandom_range(1, step_cap);
    endfunction

    function automatic logic [31:0] pick_sample_time();
        int          r;
        int          idx;
        logic [31:0] lo;
        logic [31:0] hi;
        if (shape_keys == 0)
            return $urandom;
        r   = $urandom_range(0, 9);
        idx = $urandom_range(0, shape_keys - 1);
        case (r)
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return shape_times[0];
            3: return shape_times[shape_keys - 1];
            4: return shape_times[idx];
            5: return $urandom;
            default: begin
                if (idx + 1 >= shape_keys)
                    return shape_times[idx] + $urandom_range(0, 3);
                lo = shape_times[idx];
                hi = shape_times[idx + 1];
                return (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(lo, hi);
            end
        endcase
    endfunction

    // Build or extend a table of keys, mostly in time order, then sample it.
    task automatic run_table(input int keys, input int samples, input logic fresh);
        int          n;
        logic [31:0] t;
        case ($urandom_range(0, 2))
            0: step_cap = 32'h0000_0100;
            1: step_cap = 32'h0001_0000;
            default: step_cap = 32'h0100_0000;
        endcase
        if (!fresh && shape_keys > 0)
            t = next_key_time(shape_times[shape_keys - 1]);
        else if ($urandom_range(0, 4) == 0)
            t = 32'h0;
        else
            t = $urandom_range(0, 32'h8000_0000);
        for (n = 0; n < keys; n++) begin
            send_append((n == 0) && fresh, t, rand_component(), rand_component(),
                        rand_component());
            t = next_key_time(t);
        end
        for (n = 0; n < samples; n++)
            send_sample(pick_sample_time());
    endtask

    // Fill the table to the brim, push a few appends past it, then sample.
    task automatic run_full_table();
        int n;
        run_table(MAX_KEYS, 0, 1'b1);
        for (n = 0; n < $urandom_range(1, 3); n++)
            send_append(1'b0, $urandom, $urandom, $urandom, $urandom);
        for (n = 0; n < $urandom_range(4, 10); n++)
            send_sample(pick_sample_time());
    endtask

    task automatic run_noise(input int count);
        in_word_t w;
        int       n;
        for (n = 0; n < count; n++) begin
            w = {2'($urandom), $urandom, $urandom, $urandom, $urandom};
            send_word(w);
        end
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct,
                             input bit hold_off, input bit start_full);
        int target;
        int r;
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        target         = words_sent + ITEMS_PER_PHASE;
        if (hold_off)
            hold_requests++;
        if (start_full)
            run_full_table();
        while (words_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                run_full_table();
            else if (r < 14)
                run_noise($urandom_range(1, 6));
            else if (r < 24)
                run_table($urandom_range(1, 4), $urandom_range(2, 8), 1'b0);
            else if (r < 40)
                run_table(1, $urandom_range(2, 5), 1'b1);
            else if (r < 92)
                run_table($urandom_range(2, 6), $urandom_range(2, 8), 1'b1);
            else
                run_table($urandom_range(7, 20), $urandom_range(4, 10), 1'b1);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        words_sent     = 0;
        shape_keys     = 0;
        step_cap       = 32'h0001_0000;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty table, a single key, extreme values both ways,
        // equal key times, out-of-order keys and times at every boundary.
        send_sample(32'h0000_0000);
        send_append(1'b1, 32'h0064_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_append(1'b0, 32'h00C8_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h0096_0000);
        send_sample(32'h0064_0000);
        send_sample(32'h00C8_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0064_0001);
        send_append(1'b0, 32'h00C8_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678);
        send_append(1'b0, 32'h012C_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_sample(32'h00C8_0000);
        send_sample(32'h00FA_0000);
        send_append(1'b1, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
        send_append(1'b0, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        send_append(1'b1, 32'h0000_0010, 32'h0000_0005, 32'h0000_0006, 32'h0000_0007);
        send_append(1'b0, 32'h0000_0010, 32'h0000_0008, 32'h0000_0009, 32'h0000_000A);
        send_sample(32'h0000_0010);
        send_sample(32'h0000_0011);

        // Random phases: free running, sender idling, receiver stalling with a
        // long hold-off first, and both idling a little after another hold-off.
        run_phase(0, 0, 1'b0, 1'b1);
        run_phase(58, 0, 1'b0, 1'b0);
        run_phase(0, 58, 1'b1, 1'b0);
        run_phase(15, 15, 1'b1, 1'b0);

        s_valid <= 1'b0;
        wait (outstanding == 0 && hold_requests == holds_done);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d words sent and %0d result words checked.",
                 words_sent, words_checked);
        $display("Of these: %0d interpolated samples, %0d full-table drops, %0d empty-table samples.",
                 lerps_predicted, full_predicted, empty_predicted);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("keyframe_linear_sampler test passed");
        end else begin
            $display("keyframe_linear_sampler test failed");
        end
        $finish;
    end

endmodule
